@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg)
`define ASSERT_ALWAYS(label, clk_sig, prop, msg)

`endif

`endif

@@ sv/tapc_pkg.sv @@
// ----------------------------------------------------------------------------
// tapc_pkg
// Widths, register indexes and shared types of the three-axis PID controller.
// ----------------------------------------------------------------------------
package tapc_pkg;

	// sample and axis geometry
	localparam int SAMPLE_W   = 16;
	localparam int AXIS_COUNT = 3;
	localparam int NUM_AXES   = 3;

	// gains are unsigned Q8.8, limits signed 16 bit
	localparam int GAIN_W   = 16;
	localparam int LIM_W    = 16;
	localparam int LIMITS_W = NUM_AXES * LIM_W;
	localparam int FRAC_W   = 8;
	localparam int INT_W    = 32;

	// datapath widths
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int DIFF_W   = SAMPLE_W + 2;
	localparam int P_PROD_W = ERR_W + GAIN_W + 1;
	localparam int D_PROD_W = DIFF_W + GAIN_W + 1;
	localparam int P_W      = P_PROD_W - FRAC_W;
	localparam int D_W      = D_PROD_W - FRAC_W;
	localparam int ISUM_W   = ((INT_W > P_W) ? INT_W : P_W) + 1;
	localparam int DSUM_W   = ((D_W > INT_W) ? D_W : INT_W) + 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = LIMITS_W;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIM  = 3'd4;

	localparam logic [LIMITS_W-1:0] LIMITS_RESET = {NUM_AXES{1'b0, {(LIM_W-1){1'b1}}}};

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [ERR_W-1:0]    err_t;
	typedef logic        [GAIN_W-1:0]   gain_t;
	typedef logic signed [LIM_W-1:0]    lim_t;
	typedef logic signed [INT_W-1:0]    integ_t;
	typedef logic signed [P_W-1:0]      pterm_t;
	typedef logic signed [D_W-1:0]      dterm_t;

	// scaled terms of one axis, handed from the product stage to the integrator
	typedef struct packed {
		pterm_t p;
		dterm_t d;
		pterm_t i;
	} terms_t;

endpackage

@@ sv/tapc_product.sv @@
// ----------------------------------------------------------------------------
// tapc_product
// Per-axis error, derivative difference and the three gain products, scaled
// by 2^-8 and registered into stage 2. Holds the previous error of the axis.
// ----------------------------------------------------------------------------
module tapc_product (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  tapc_pkg::sample_t  measured,
	input  tapc_pkg::sample_t  goal,
	input  tapc_pkg::gain_t    gain_p,
	input  tapc_pkg::gain_t    gain_i,
	input  tapc_pkg::gain_t    gain_d,
	output tapc_pkg::terms_t   terms_s2
);

	tapc_pkg::err_t                          prev_err_q;
	tapc_pkg::err_t                          err;
	logic signed [tapc_pkg::DIFF_W-1:0]      diff;
	logic signed [tapc_pkg::GAIN_W:0]        gp;
	logic signed [tapc_pkg::GAIN_W:0]        gi;
	logic signed [tapc_pkg::GAIN_W:0]        gd;
	logic signed [tapc_pkg::P_PROD_W-1:0]    p_prod;
	logic signed [tapc_pkg::P_PROD_W-1:0]    i_prod;
	logic signed [tapc_pkg::D_PROD_W-1:0]    d_prod;
	tapc_pkg::terms_t                        terms;

	// error and its change since the last item
	always_comb begin
		err  = tapc_pkg::ERR_W'(goal) - tapc_pkg::ERR_W'(measured);
		diff = tapc_pkg::DIFF_W'(err) - tapc_pkg::DIFF_W'(prev_err_q);
	end

	// gains are unsigned: widen with a zero sign bit
	assign gp = $signed({1'b0, gain_p});
	assign gi = $signed({1'b0, gain_i});
	assign gd = $signed({1'b0, gain_d});

	// products, floored by the arithmetic shift
	always_comb begin
		p_prod  = tapc_pkg::P_PROD_W'(err) * tapc_pkg::P_PROD_W'(gp);
		i_prod  = tapc_pkg::P_PROD_W'(err) * tapc_pkg::P_PROD_W'(gi);
		d_prod  = tapc_pkg::D_PROD_W'(diff) * tapc_pkg::D_PROD_W'(gd);
		terms.p = tapc_pkg::P_W'(p_prod >>> tapc_pkg::FRAC_W);
		terms.i = tapc_pkg::P_W'(i_prod >>> tapc_pkg::FRAC_W);
		terms.d = tapc_pkg::D_W'(d_prod >>> tapc_pkg::FRAC_W);
	end

	// remember the error of the item that moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (load) begin
			prev_err_q <= err;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (load) begin
			terms_s2 <= terms;
		end
	end

endmodule

@@ sv/tapc_integrate.sv @@
// ----------------------------------------------------------------------------
// tapc_integrate
// Per-axis integral update with upper limit and lower saturation, then the
// summed drive with its own clamps, registered as the result of the axis.
// ----------------------------------------------------------------------------
module tapc_integrate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  tapc_pkg::terms_t   terms,
	input  tapc_pkg::lim_t     int_limit,
	input  tapc_pkg::lim_t     out_limit,
	output tapc_pkg::sample_t  drive_q
);

	localparam logic signed [tapc_pkg::ISUM_W-1:0] IMIN =
		{{(tapc_pkg::ISUM_W - tapc_pkg::INT_W + 1){1'b1}}, {(tapc_pkg::INT_W-1){1'b0}}};
	localparam logic signed [tapc_pkg::DSUM_W-1:0] DMIN =
		{{(tapc_pkg::DSUM_W - tapc_pkg::SAMPLE_W + 1){1'b1}}, {(tapc_pkg::SAMPLE_W-1){1'b0}}};

	tapc_pkg::integ_t                      integral_q;
	logic signed [tapc_pkg::ISUM_W-1:0]    isum;
	logic signed [tapc_pkg::ISUM_W-1:0]    ilim;
	tapc_pkg::integ_t                      integ;
	logic signed [tapc_pkg::DSUM_W-1:0]    dsum;
	logic signed [tapc_pkg::DSUM_W-1:0]    olim;
	tapc_pkg::sample_t                     drive;

	// accumulate, clamp above by the limit, saturate below
	always_comb begin
		isum = tapc_pkg::ISUM_W'(integral_q) + tapc_pkg::ISUM_W'($signed(terms.i));
		ilim = tapc_pkg::ISUM_W'(int_limit);
		if (isum > ilim) begin
			integ = tapc_pkg::INT_W'(ilim);
		end else if (isum < IMIN) begin
			integ = tapc_pkg::INT_W'(IMIN);
		end else begin
			integ = tapc_pkg::INT_W'(isum);
		end
	end

	// sum the terms, clamp above by the limit, saturate below
	always_comb begin
		dsum = tapc_pkg::DSUM_W'($signed(terms.p)) + tapc_pkg::DSUM_W'($signed(terms.d))
			+ tapc_pkg::DSUM_W'(integ);
		olim = tapc_pkg::DSUM_W'(out_limit);
		if (dsum > olim) begin
			drive = tapc_pkg::SAMPLE_W'(olim);
		end else if (dsum < DMIN) begin
			drive = tapc_pkg::SAMPLE_W'(DMIN);
		end else begin
			drive = tapc_pkg::SAMPLE_W'(dsum);
		end
	end

	// integral state advances with the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (load) begin
			integral_q <= integ;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			drive_q <= drive;
		end
	end

endmodule

@@ sv/three_axis_pid_controller.sv @@
// ----------------------------------------------------------------------------
// three_axis_pid_controller
// Positional PID controller on three axes, Q8.8 fixed point, with a clamped
// integral and a clamped drive per axis.
//
//   channel  signals                            direction
//   -------  ---------------------------------  ---------
//   in       in_valid/in_ready, measured_*,     into block
//            goal_*
//   out      out_valid/out_ready, drive_*       out of block
//   cfg      cfg_en, cfg_index, cfg_data        into block
//
// One item per cycle sustained while out_ready allows; an accepted item passes the
// input register, product register and result register on its way to out_valid.
// The integral of an axis updates as its item enters the result register,
// so back-to-back items chain through that single adder and clamp.
// Reset empties all stages and clears previous errors and integrals.
// Each stage holds while the stage after it is full and stalled; in_ready
// drops only when all three stages hold items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_axis_pid_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  tapc_pkg::sample_t                 measured_x,
	input  tapc_pkg::sample_t                 measured_y,
	input  tapc_pkg::sample_t                 measured_z,
	input  tapc_pkg::sample_t                 goal_x,
	input  tapc_pkg::sample_t                 goal_y,
	input  tapc_pkg::sample_t                 goal_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tapc_pkg::sample_t                 drive_x,
	output tapc_pkg::sample_t                 drive_y,
	output tapc_pkg::sample_t                 drive_z,
	input  logic                              cfg_en,
	input  logic [tapc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tapc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	tapc_pkg::gain_t                  gain_p_q;
	tapc_pkg::gain_t                  gain_i_q;
	tapc_pkg::gain_t                  gain_d_q;
	logic [tapc_pkg::LIMITS_W-1:0]    out_limits_q;
	logic [tapc_pkg::LIMITS_W-1:0]    int_limits_q;

	logic                             v1_q;
	logic                             v2_q;
	logic                             out_valid_q;
	logic                             in_fire;
	logic                             rdy3;
	logic                             rdy2;
	logic                             adv_s2;
	logic                             adv_out;

	tapc_pkg::sample_t                meas_in [tapc_pkg::NUM_AXES];
	tapc_pkg::sample_t                goal_in [tapc_pkg::NUM_AXES];
	tapc_pkg::sample_t                meas_s1 [tapc_pkg::NUM_AXES];
	tapc_pkg::sample_t                goal_s1 [tapc_pkg::NUM_AXES];
	tapc_pkg::sample_t                drive_q [tapc_pkg::NUM_AXES];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			out_limits_q <= tapc_pkg::LIMITS_RESET;
			int_limits_q <= tapc_pkg::LIMITS_RESET;
		end else if (cfg_en) begin
			unique case (cfg_index)
				tapc_pkg::REG_GAIN_P:  gain_p_q     <= cfg_data[tapc_pkg::GAIN_W-1:0];
				tapc_pkg::REG_GAIN_I:  gain_i_q     <= cfg_data[tapc_pkg::GAIN_W-1:0];
				tapc_pkg::REG_GAIN_D:  gain_d_q     <= cfg_data[tapc_pkg::GAIN_W-1:0];
				tapc_pkg::REG_OUT_LIM: out_limits_q <= cfg_data[tapc_pkg::LIMITS_W-1:0];
				tapc_pkg::REG_INT_LIM: int_limits_q <= cfg_data[tapc_pkg::LIMITS_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control: each stage loads when empty or draining
	assign rdy3     = !out_valid_q || out_ready;
	assign adv_out  = v2_q && rdy3;
	assign rdy2     = !v2_q || rdy3;
	assign adv_s2   = v1_q && rdy2;
	assign in_ready = !v1_q || rdy2;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				v1_q <= 1'b1;
			end else if (adv_s2) begin
				v1_q <= 1'b0;
			end
			if (adv_s2) begin
				v2_q <= 1'b1;
			end else if (adv_out) begin
				v2_q <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign meas_in[0] = measured_x;
	assign meas_in[1] = measured_y;
	assign meas_in[2] = measured_z;
	assign goal_in[0] = goal_x;
	assign goal_in[1] = goal_y;
	assign goal_in[2] = goal_z;

	// input register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int a = 0; a < tapc_pkg::NUM_AXES; a++) begin
				meas_s1[a] <= meas_in[a];
				goal_s1[a] <= goal_in[a];
			end
		end
	end

	// per-axis datapath; axes beyond the configured count output zero
	for (genvar a = 0; a < tapc_pkg::NUM_AXES; a++) begin : g_axis
		if (a < tapc_pkg::AXIS_COUNT) begin : g_on
			tapc_pkg::terms_t terms_s2;

			tapc_product u_product (
				.clk      (clk),
				.arst_n   (arst_n),
				.load     (adv_s2),
				.measured (meas_s1[a]),
				.goal     (goal_s1[a]),
				.gain_p   (gain_p_q),
				.gain_i   (gain_i_q),
				.gain_d   (gain_d_q),
				.terms_s2 (terms_s2)
			);

			tapc_integrate u_integrate (
				.clk       (clk),
				.arst_n    (arst_n),
				.load      (adv_out),
				.terms     (terms_s2),
				.int_limit (int_limits_q[a*tapc_pkg::LIM_W +: tapc_pkg::LIM_W]),
				.out_limit (out_limits_q[a*tapc_pkg::LIM_W +: tapc_pkg::LIM_W]),
				.drive_q   (drive_q[a])
			);
		end else begin : g_off
			assign drive_q[a] = '0;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_x   = drive_q[0];
	assign drive_y   = drive_q[1];
	assign drive_z   = drive_q[2];

	// checks
	`ASSERT_CLK(a_blocked_only_when_full, clk, arst_n, !in_ready |-> (v1_q && v2_q && out_valid_q), "in_ready low with a free stage")
	`ASSERT_CLK(a_stage2_holds_on_stall, clk, arst_n, (v2_q && out_valid_q && !out_ready) |=> (v2_q && out_valid_q), "stage 2 item lost during output stall")
	`ASSERT_ALWAYS(a_reset_empties, clk, !arst_n |=> !out_valid_q, "result valid right after reset")

endmodule
